[src/timestamped_pid_duty_controller_assert.svh]
// assertion macros shared by the pid duty controller rtl
// expects aclk and aresetn in the scope where a macro is used
`ifndef TIMESTAMPED_PID_DUTY_CONTROLLER_ASSERT_SVH
`define TIMESTAMPED_PID_DUTY_CONTROLLER_ASSERT_SVH

// same-cycle implication, held off during reset
`define TPDC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define TPDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tpdc_pkg.sv]
// types and constants of the pid duty controller
// no dependencies
`default_nettype none

package tpdc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 31;
    localparam int GAIN_W    = 16;
    localparam int DUTY_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int CFG_IDX_W = 2;

    // duty limit of 100.0 with sixteen fraction bits
    localparam int DUTY_LIM_Q16 = 100 << 16;

    localparam logic signed [DUTY_W-1:0] DUTY_MAX = 16'sd25600;
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = -16'sd25600;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = -16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = -16'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_D = 2'd1,
        CFG_GAIN_I = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] theta;
        logic        [TIME_W-1:0]   sample_time;
    } sample_t;

    typedef struct packed {
        logic signed [DUTY_W-1:0] duty;
        logic                     clipped;
    } duty_t;

endpackage

`default_nettype wire

[src/timestamped_pid_duty_controller.sv]
// takes one beat at a time: s_ready is high only in idle, so no new beat enters before the last result is registered
// the work runs on one shared add/subtract unit stepping a bit at a time: 16 divide steps,
// 16 integral multiply steps and 3 x 16 gain multiply steps, plus the setup states diff, mag, sign, sat and clip
// a new beat is taken while the previous result still waits in the output register
// reset (synchronous, aresetn low): gains to -1.0, +1.0, -1.0, no sample seen, integral 0
// pid datapath, sequencer and config registers; uses tpdc_pkg and the assertion header
`default_nettype none

`include "timestamped_pid_duty_controller_assert.svh"

module timestamped_pid_duty_controller #(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_we,
    input  wire logic [tpdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tpdc_pkg::GAIN_W-1:0]        cfg_wdata,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire tpdc_pkg::sample_t                  s_data,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output tpdc_pkg::duty_t                         m_data
);

    localparam int SW = tpdc_pkg::SAMPLE_W;
    localparam int TW = tpdc_pkg::TIME_W;
    localparam int GW = tpdc_pkg::GAIN_W;
    localparam int FW = tpdc_pkg::FRAC_W;
    localparam int DW = tpdc_pkg::DUTY_W;

    // datapath width: integral update, gain x integral, and the pid sum
    localparam int PW_A  = ACC_WIDTH + GW;
    localparam int PW_B  = SW + TW + 1;
    localparam int PW_C  = SW + GW + 2;
    localparam int PW_AB = (PW_A > PW_B) ? PW_A : PW_B;
    localparam int PW    = ((PW_AB > PW_C) ? PW_AB : PW_C) + 1;

    localparam int BW    = (SW > GW) ? SW : GW;
    localparam int CNT_W = $clog2(BW);

    localparam logic signed [PW-1:0] LIM_POS = PW'(tpdc_pkg::DUTY_LIM_Q16);
    localparam logic signed [PW-1:0] LIM_NEG = -LIM_POS;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MAG,
        ST_DIV,
        ST_SIGN,
        ST_INTEG,
        ST_SAT,
        ST_GP,
        ST_GD,
        ST_GI,
        ST_CLIP
    } state_t;

    state_t                        state_reg;

    logic signed [GW-1:0]          gain_p_reg;
    logic signed [GW-1:0]          gain_d_reg;
    logic signed [GW-1:0]          gain_i_reg;

    logic                          started_reg;
    logic signed [SW-1:0]          prev_theta_reg;
    logic        [TW-1:0]          prev_time_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg;

    logic signed [SW-1:0]          theta_reg;
    logic        [TW-1:0]          time_reg;
    logic signed [TW:0]            dt_reg;
    logic signed [SW:0]            num_reg;
    logic        [TW-1:0]          dt_mag_reg;
    logic        [SW-1:0]          num_mag_reg;
    logic                          neg_reg;
    logic                          dt_zero_reg;
    logic        [TW-1:0]          rem_reg;
    logic        [SW-1:0]          quo_reg;
    logic signed [SW:0]            deriv_reg;

    logic signed [PW-1:0]          x_reg;
    logic signed [PW-1:0]          m_reg;
    logic        [BW-1:0]          b_reg;
    logic        [CNT_W-1:0]       cnt_reg;

    logic                          m_valid_reg;
    tpdc_pkg::duty_t               m_data_reg;

    logic signed [PW-1:0]          add_a;
    logic signed [PW-1:0]          add_b;
    logic                          add_sub;
    logic signed [PW-1:0]          add_y;
    logic                          acc_fits;
    logic                          over;
    logic                          under;
    logic                          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // the shared add/subtract unit
    always_comb begin
        add_a   = x_reg;
        add_b   = m_reg;
        add_sub = 1'b0;
        case (state_reg)
            ST_DIV: begin
                add_a   = {{(PW-TW-1){1'b0}}, rem_reg, num_mag_reg[SW-1]};
                add_b   = {{(PW-TW){1'b0}}, dt_mag_reg};
                add_sub = 1'b1;
            end
            ST_INTEG, ST_GP, ST_GD, ST_GI: begin
                // top multiplier bit carries negative weight
                add_sub = (cnt_reg == '0);
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        add_y = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    always_comb begin
        acc_fits = (&x_reg[PW-1:ACC_WIDTH-1]) || !(|x_reg[PW-1:ACC_WIDTH-1]);
        over     = (x_reg > LIM_POS);
        under    = (x_reg < LIM_NEG);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= tpdc_pkg::GAIN_P_RST;
            gain_d_reg <= tpdc_pkg::GAIN_D_RST;
            gain_i_reg <= tpdc_pkg::GAIN_I_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tpdc_pkg::CFG_GAIN_P: gain_p_reg <= cfg_wdata;
                tpdc_pkg::CFG_GAIN_D: gain_d_reg <= cfg_wdata;
                tpdc_pkg::CFG_GAIN_I: gain_i_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer, datapath registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            prev_theta_reg <= '0;
            prev_time_reg  <= '0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        theta_reg <= s_data.theta;
                        time_reg  <= s_data.sample_time;
                        state_reg <= ST_DIFF;
                    end
                end

                ST_DIFF: begin
                    if (started_reg) begin
                        dt_reg  <= $signed({1'b0, time_reg}) - $signed({1'b0, prev_time_reg});
                        num_reg <= (SW+1)'(theta_reg) - (SW+1)'(prev_theta_reg);
                    end else begin
                        // first beat is its own reference
                        dt_reg      <= '0;
                        num_reg     <= '0;
                        acc_reg     <= '0;
                        started_reg <= 1'b1;
                    end
                    prev_theta_reg <= theta_reg;
                    prev_time_reg  <= time_reg;
                    state_reg      <= ST_MAG;
                end

                ST_MAG: begin
                    neg_reg     <= num_reg[SW] ^ dt_reg[TW];
                    dt_zero_reg <= (dt_reg == '0);
                    dt_mag_reg  <= dt_reg[TW] ? TW'(-dt_reg) : TW'(dt_reg);
                    num_mag_reg <= num_reg[SW] ? SW'(-num_reg) : SW'(num_reg);
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    cnt_reg     <= CNT_W'(SW-1);
                    state_reg   <= ST_DIV;
                end

                ST_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (add_y[PW-1]) begin
                        rem_reg <= {rem_reg[TW-2:0], num_mag_reg[SW-1]};
                    end else begin
                        rem_reg <= add_y[TW-1:0];
                    end
                    quo_reg     <= {quo_reg[SW-2:0], !add_y[PW-1]};
                    num_mag_reg <= {num_mag_reg[SW-2:0], 1'b0};
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_SIGN;
                    end
                end

                ST_SIGN: begin
                    if (dt_zero_reg) begin
                        deriv_reg <= '0;
                    end else if (neg_reg) begin
                        deriv_reg <= -$signed({1'b0, quo_reg});
                    end else begin
                        deriv_reg <= $signed({1'b0, quo_reg});
                    end
                    // integral gets theta * dt added on top
                    x_reg     <= PW'(acc_reg);
                    m_reg     <= PW'(dt_reg);
                    b_reg     <= BW'($unsigned(theta_reg));
                    cnt_reg   <= CNT_W'(SW-1);
                    state_reg <= ST_INTEG;
                end

                ST_INTEG, ST_GP, ST_GD, ST_GI: begin
                    if (b_reg[0]) begin
                        x_reg <= add_y;
                    end
                    m_reg   <= m_reg <<< 1;
                    b_reg   <= b_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        unique case (state_reg)
                            ST_INTEG: begin
                                state_reg <= ST_SAT;
                            end
                            ST_GP: begin
                                m_reg     <= PW'(deriv_reg);
                                b_reg     <= BW'($unsigned(gain_d_reg));
                                cnt_reg   <= CNT_W'(GW-1);
                                state_reg <= ST_GD;
                            end
                            ST_GD: begin
                                m_reg     <= PW'(acc_reg);
                                b_reg     <= BW'($unsigned(gain_i_reg));
                                cnt_reg   <= CNT_W'(GW-1);
                                state_reg <= ST_GI;
                            end
                            default: begin
                                state_reg <= ST_CLIP;
                            end
                        endcase
                    end
                end

                ST_SAT: begin
                    if (acc_fits) begin
                        acc_reg <= x_reg[ACC_WIDTH-1:0];
                    end else begin
                        acc_reg <= x_reg[PW-1] ? ACC_MIN : ACC_MAX;
                    end
                    // pid sum starts with the proportional term
                    x_reg     <= '0;
                    m_reg     <= PW'(theta_reg);
                    b_reg     <= BW'($unsigned(gain_p_reg));
                    cnt_reg   <= CNT_W'(GW-1);
                    state_reg <= ST_GP;
                end

                ST_CLIP: begin
                    if (out_free) begin
                        if (over) begin
                            m_data_reg.duty    <= tpdc_pkg::DUTY_MAX;
                            m_data_reg.clipped <= 1'b1;
                        end else if (under) begin
                            m_data_reg.duty    <= tpdc_pkg::DUTY_MIN;
                            m_data_reg.clipped <= 1'b1;
                        end else begin
                            // floor to eight fraction bits
                            m_data_reg.duty    <= x_reg[DW+FW-1:FW];
                            m_data_reg.clipped <= 1'b0;
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `TPDC_ASSERT_IMPL(a_duty_range, m_valid, (m_data.duty <= tpdc_pkg::DUTY_MAX) && (m_data.duty >= tpdc_pkg::DUTY_MIN), "duty outside the clip limits")
    `TPDC_ASSERT_IMPL(a_clip_at_limit, m_valid && m_data.clipped, (m_data.duty == tpdc_pkg::DUTY_MAX) || (m_data.duty == tpdc_pkg::DUTY_MIN), "clipped beat not at a limit")
    `TPDC_ASSERT_NEXT(a_busy_after_beat, s_valid && s_ready, !s_ready, "ready held after an accepted beat")
    `TPDC_ASSERT_IMPL(a_result_from_clip, $rose(m_valid_reg), $past(state_reg == ST_CLIP), "result raised outside the clip step")

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking testbench for timestamped_pid_duty_controller: directed and random samples
// depends on tpdc_pkg and the controller rtl; checks each duty beat against a built-in predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ACC_WIDTH        = 48;
    localparam longint      ACC_HI           = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    localparam longint      ACC_LO           = -ACC_HI - 1;
    localparam longint      ACC_RECENTRE     = longint'(1) <<< 24;
    localparam longint      TIME_MAX         = (longint'(1) <<< tpdc_pkg::TIME_W) - 1;
    localparam int          THETA_MAX        = 32767;
    localparam int          THETA_MIN        = -32768;
    localparam logic [tpdc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int          LONG_HOLD_CYCLES = 600;
    localparam int          CYCLE_LIMIT      = 2_000_000;
    localparam int          RANDOM_PHASES    = 6;
    localparam int          PHASE_SAMPLES    = 180;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               cfg_we;
    logic [tpdc_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [tpdc_pkg::GAIN_W-1:0]        cfg_wdata;
    logic                               s_valid;
    logic                               s_ready;
    tpdc_pkg::sample_t                  s_data;
    logic                               m_valid;
    logic                               m_ready;
    tpdc_pkg::duty_t                    m_data;

    // predictor state, mirrors the controller
    logic signed [tpdc_pkg::GAIN_W-1:0]   kp = tpdc_pkg::GAIN_P_RST;
    logic signed [tpdc_pkg::GAIN_W-1:0]   kd = tpdc_pkg::GAIN_D_RST;
    logic signed [tpdc_pkg::GAIN_W-1:0]   ki = tpdc_pkg::GAIN_I_RST;
    bit                                   pid_started = 1'b0;
    logic signed [tpdc_pkg::SAMPLE_W-1:0] prev_theta_m = '0;
    logic [tpdc_pkg::TIME_W-1:0]          last_time = '0;
    longint                               integ_acc = 0;

    tpdc_pkg::duty_t  duty_expected_q[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     idling_on = 1'b1;
    bit     long_hold_req = 1'b0;

    timestamped_pid_duty_controller #(
        .ACC_WIDTH(ACC_WIDTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic tpdc_pkg::duty_t predict_duty(input tpdc_pkg::sample_t smp);
        longint th;
        longint dt;
        longint slope;
        longint acc_sum;
        longint total;
        longint scaled;
        tpdc_pkg::duty_t  res;
        th = longint'($signed(smp.theta));
        // first sample becomes the reference point
        if (!pid_started) begin
            pid_started  = 1'b1;
            prev_theta_m = smp.theta;
            last_time    = smp.sample_time;
            integ_acc    = 0;
        end
        dt = longint'(smp.sample_time) - longint'(last_time);
        slope = (dt == 0) ? 0 : (th - longint'(prev_theta_m)) / dt;
        acc_sum = integ_acc + th * dt;
        if (acc_sum > ACC_HI) begin
            acc_sum = ACC_HI;
        end else if (acc_sum < ACC_LO) begin
            acc_sum = ACC_LO;
        end
        integ_acc = acc_sum;
        total = longint'(kp) * th + longint'(kd) * slope + longint'(ki) * integ_acc;
        if (total > longint'(tpdc_pkg::DUTY_LIM_Q16)) begin
            res.duty    = tpdc_pkg::DUTY_MAX;
            res.clipped = 1'b1;
        end else if (total < -longint'(tpdc_pkg::DUTY_LIM_Q16)) begin
            res.duty    = tpdc_pkg::DUTY_MIN;
            res.clipped = 1'b1;
        end else begin
            // floor to eight fraction bits
            scaled      = total >>> tpdc_pkg::FRAC_W;
            res.duty    = scaled[tpdc_pkg::DUTY_W-1:0];
            res.clipped = 1'b0;
        end
        prev_theta_m = smp.theta;
        last_time    = smp.sample_time;
        return res;
    endfunction

    function automatic tpdc_pkg::sample_t mk_sample(input int th, input longint tstamp);
        tpdc_pkg::sample_t smp;
        smp.theta       = th[tpdc_pkg::SAMPLE_W-1:0];
        smp.sample_time = tstamp[tpdc_pkg::TIME_W-1:0];
        return smp;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [tpdc_pkg::GAIN_W-1:0] pick_gain();
        int unsigned r;
        int          g;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            g = int'($urandom_range(0, 128)) - 64;
        end else if (r < 80) begin
            g = int'($urandom_range(0, 2048)) - 1024;
        end else if (r < 90) begin
            g = int'($urandom);
        end else begin
            g = $urandom_range(0, 1) ? THETA_MAX : THETA_MIN;
        end
        return g[tpdc_pkg::GAIN_W-1:0];
    endfunction

    function automatic tpdc_pkg::sample_t make_random_sample();
        int unsigned r;
        longint      lt;
        longint      mag;
        longint      d;
        longint      th;
        longint      tstamp;
        lt = longint'(last_time);
        // pull a large integral back towards zero so the gains stay visible
        if ((integ_acc > ACC_RECENTRE || integ_acc < -ACC_RECENTRE)
                && $urandom_range(0, 1)) begin
            mag = (integ_acc < 0) ? -integ_acc : integ_acc;
            d = mag / THETA_MAX + 1;
            if (d > (longint'(1) <<< 30)) begin
                d = longint'(1) <<< 30;
            end
            if (lt + d > TIME_MAX) begin
                d = -d;
            end
            tstamp = lt + d;
            th = -integ_acc / d;
            if (th > THETA_MAX) begin
                th = THETA_MAX;
            end else if (th < THETA_MIN) begin
                th = THETA_MIN;
            end
            return mk_sample(int'(th), tstamp);
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            th = longint'($signed(16'($urandom)));
        end else if (r < 85) begin
            th = longint'($urandom_range(0, 4096)) - 2048;
        end else if (r < 95) begin
            th = longint'($urandom_range(0, 32)) - 16;
        end else begin
            th = $urandom_range(0, 1) ? THETA_MAX : THETA_MIN;
        end
        r = $urandom_range(0, 99);
        d = $urandom_range(1, 64);
        if (r < 10) begin
            tstamp = lt;
        end else if (r < 22) begin
            tstamp = (lt >= d) ? lt - d : lt + d;
        end else if (r < 27) begin
            tstamp = longint'($urandom) & TIME_MAX;
        end else if (r < 30) begin
            tstamp = $urandom_range(0, 1) ? TIME_MAX : 0;
        end else begin
            tstamp = (lt <= TIME_MAX - d) ? lt + d : lt - d;
        end
        return mk_sample(int'(th), tstamp);
    endfunction

    // offer one beat and keep it up until it is taken
    task automatic send_sample(input tpdc_pkg::sample_t smp);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        duty_expected_q.push_back(predict_duty(smp));
    endtask

    task automatic hold_input(input int unsigned cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (duty_expected_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [tpdc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tpdc_pkg::GAIN_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            tpdc_pkg::CFG_GAIN_P: kp = val;
            tpdc_pkg::CFG_GAIN_D: kd = val;
            tpdc_pkg::CFG_GAIN_I: ki = val;
            default: ;
        endcase
    endtask

    task automatic test_first_sample();
        send_sample(mk_sample(100, 1000));
        send_sample(mk_sample(THETA_MIN, 1000));   // no time step
        send_sample(mk_sample(THETA_MAX, 1001));
        send_sample(mk_sample(1000, 990));         // time running backwards
        send_sample(mk_sample(0, 0));
    endtask

    task automatic test_integral_saturation();
        // three large steps of the same sign push the integral to its top
        send_sample(mk_sample(THETA_MAX, TIME_MAX));
        send_sample(mk_sample(THETA_MIN, 0));
        send_sample(mk_sample(THETA_MAX, TIME_MAX));
        // then the other way, down to the bottom
        send_sample(mk_sample(THETA_MAX, 0));
        send_sample(mk_sample(THETA_MIN, TIME_MAX));
        send_sample(mk_sample(THETA_MAX, 0));
        send_sample(mk_sample(THETA_MIN, TIME_MAX));
        send_sample(mk_sample(THETA_MAX, 0));
    endtask

    task automatic test_clip_boundary();
        drain_results();
        write_gain(tpdc_pkg::CFG_GAIN_P, 16'sd256);
        write_gain(tpdc_pkg::CFG_GAIN_D, 16'sd0);
        write_gain(tpdc_pkg::CFG_GAIN_I, 16'sd0);
        // exactly 100.0 is passed, one lsb more is clipped
        send_sample(mk_sample(25600, 0));
        send_sample(mk_sample(25601, 0));
        send_sample(mk_sample(-25600, 0));
        send_sample(mk_sample(-25601, 0));
        drain_results();
        write_gain(tpdc_pkg::CFG_GAIN_P, 16'sd1);
        // rounding towards minus infinity
        send_sample(mk_sample(-1, 0));
        send_sample(mk_sample(255, 0));
    endtask

    task automatic test_gain_extremes();
        drain_results();
        write_gain(tpdc_pkg::CFG_GAIN_P, 16'sh7fff);
        write_gain(tpdc_pkg::CFG_GAIN_D, 16'sh8000);
        write_gain(tpdc_pkg::CFG_GAIN_I, 16'sh8000);
        // ignored register index must leave the gains alone
        write_gain(CFG_UNUSED_IDX, 16'h5a5a);
        send_sample(mk_sample(THETA_MIN, 0));
        send_sample(mk_sample(THETA_MAX, 1));
        drain_results();
        write_gain(tpdc_pkg::CFG_GAIN_P, 16'sd0);
        write_gain(tpdc_pkg::CFG_GAIN_D, 16'sd0);
        write_gain(tpdc_pkg::CFG_GAIN_I, 16'sd0);
        send_sample(mk_sample(THETA_MAX, 2));
    endtask

    task automatic test_output_backpressure();
        drain_results();
        idling_on = 1'b0;
        long_hold_req = 1'b1;
        // keep offering while the result side is held off, so the input stalls
        repeat (8) send_sample(make_random_sample());
        drain_results();
        idling_on = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            write_gain(tpdc_pkg::CFG_GAIN_P, pick_gain());
            write_gain(tpdc_pkg::CFG_GAIN_D, pick_gain());
            write_gain(tpdc_pkg::CFG_GAIN_I, pick_gain());
            write_gain(CFG_UNUSED_IDX, 16'($urandom));
            // one phase runs flat out on both sides
            idling_on = (ph != 2);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                if (idling_on && $urandom_range(0, 3) == 0) begin
                    hold_input(pick_gap());
                end
                send_sample(make_random_sample());
            end
        end
        drain_results();
    endtask

    initial begin : ready_driver
        int unsigned stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : duty_checker
        tpdc_pkg::duty_t want;
        if (aresetn && m_valid && m_ready) begin
            if (duty_expected_q.size() == 0) begin
                report_error($sformatf("duty beat %0d with nothing expected", m_data.duty));
            end else begin
                want = duty_expected_q.pop_front();
                if (m_data.duty !== want.duty) begin
                    report_error($sformatf("duty got %0d expected %0d",
                                           m_data.duty, want.duty));
                end
                if (m_data.clipped !== want.clipped) begin
                    report_error($sformatf("clipped got %0b expected %0b",
                                           m_data.clipped, want.clipped));
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_first_sample();
        test_integral_saturation();
        test_clip_boundary();
        test_gain_extremes();
        test_output_backpressure();
        test_random_phases();

        // allow for any stray beat after the last one expected
        repeat (120) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
